// ----- rtl/core/tcw_pkg.sv -----
// Shared types and constants for the text console cell writer.
package tcw_pkg;

   localparam int COLUMNS    = 106;
   localparam int ROWS       = 24;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int CUR_COL_W  = $clog2(COLUMNS);
   localparam int CUR_ROW_W  = $clog2(ROWS);

   localparam int OP_W    = 1;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int INDEX_W = 12;
   localparam int VALUE_W = 16;

   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0F;

   localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
   localparam logic [OP_W-1:0] OP_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } state_type;

endpackage

// ----- rtl/core/tcw_if.sv -----
// Request and response channel interfaces of the text console cell writer.
interface tcw_req_if
   import tcw_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CHAR_W-1:0] char_code;
   logic [ROW_W-1:0]  read_row;
   logic [COL_W-1:0]  read_col;

   modport source (output valid, output op, output char_code, output read_row,
                   output read_col, input ready);
   modport sink (input valid, input op, input char_code, input read_row,
                 input read_col, output ready);
endinterface

interface tcw_rsp_if
   import tcw_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] cell_index;
   logic [VALUE_W-1:0] cell_value;
   logic               scrolled;

   modport source (output valid, output cell_index, output cell_value,
                   output scrolled, input ready);
   modport sink (input valid, input cell_index, input cell_value,
                 input scrolled, output ready);
endinterface

// ----- rtl/core/text_console_cell_writer.sv -----
// Text console screen store with cursor, scroll and cell read-back.
//
// Words enter on req_chan and leave on rsp_chan; a word moves at a rising
// clock edge where valid and ready are both high. Every request word gives
// exactly one response word. A put writes the character with the current
// color at the cursor and reports that cell; a read reports one cell.
// The color register is written through csr_wr_en and csr_wr_data.
// A put's response is registered one cycle after acceptance and the next
// word may be taken in that same cycle, so puts run at one per cycle.
// A read in range goes through the screen memory's registered read port
// and ST_READ before its response is registered; a read out of range
// loads the response register directly. A put that wraps past the
// bottom row copies the screen up by one row, one cell per cycle, and
// holds off requests in ST_SCROLL until the copy is done.
// After reset the block clears every cell of the screen, one cell per
// cycle, before it takes any request.
// When the receiver stalls, the response stays in the output register and
// the block takes no further request until that word has been taken.
module text_console_cell_writer
   import tcw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   tcw_req_if.sink            req_chan,
   tcw_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [COLOR_W-1:0] csr_wr_data
);

   localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_START  = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [CNT_W-1:0]  COPY_START    = CNT_W'(COLUMNS);
   localparam logic [CNT_W-1:0]  COPY_END      = CNT_W'(CELL_COUNT);
   localparam logic [CUR_COL_W-1:0] LAST_COL   = CUR_COL_W'(COLUMNS - 1);
   localparam logic [CUR_ROW_W-1:0] LAST_ROW   = CUR_ROW_W'(ROWS - 1);

   logic [VALUE_W-1:0] screen_mem [CELL_COUNT];
   logic [VALUE_W-1:0] mem_rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   state_type            state_ff, state_in;
   logic [CUR_COL_W-1:0] col_ff, col_in;
   logic [CUR_ROW_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0]    cur_idx_ff, cur_idx_in;
   logic [CNT_W-1:0]     copy_rd_ff, copy_rd_in;
   logic [ADDR_W-1:0]    copy_wr_ff, copy_wr_in;
   logic                 copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [COLOR_W-1:0]   color_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;

   logic               req_fire;
   logic               read_in_range;
   logic [ADDR_W-1:0]  read_addr;
   logic [VALUE_W-1:0] put_value;

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign read_in_range = (int'(req_chan.read_row) < ROWS) &&
                          (int'(req_chan.read_col) < COLUMNS);
   assign read_addr = ADDR_W'(int'(req_chan.read_row) * COLUMNS + int'(req_chan.read_col));
   assign put_value = {color_ff, req_chan.char_code};

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_index = rsp_index_ff;
   assign rsp_chan.cell_value = rsp_value_ff;
   assign rsp_chan.scrolled   = rsp_scrolled_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= screen_mem[mem_raddr];
   end

   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      cur_idx_in      = cur_idx_ff;
      copy_rd_in      = copy_rd_ff;
      copy_wr_in      = copy_wr_ff;
      copy_pend_in    = copy_pend_ff;
      clr_in          = clr_ff;
      rd_idx_in       = rd_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in    = rsp_index_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      mem_we          = 1'b0;
      mem_waddr       = cur_idx_ff;
      mem_wdata       = put_value;
      mem_raddr       = read_addr;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.op == OP_PUT) begin
                  mem_we          = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_index_in    = INDEX_W'(cur_idx_ff);
                  rsp_value_in    = put_value;
                  rsp_scrolled_in = 1'b0;
                  cur_idx_in      = cur_idx_ff + 1'b1;
                  col_in          = col_ff + 1'b1;
                  if (col_ff == LAST_COL) begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        cur_idx_in      = BOTTOM_START;
                        rsp_scrolled_in = 1'b1;
                        copy_rd_in      = COPY_START;
                        copy_pend_in    = 1'b0;
                        state_in        = ST_SCROLL;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
               end else if (read_in_range) begin
                  rd_idx_in = read_addr;
                  state_in  = ST_READ;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_index_in    = '0;
                  rsp_value_in    = '0;
                  rsp_scrolled_in = 1'b0;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in    = 1'b1;
            rsp_index_in    = INDEX_W'(rd_idx_ff);
            rsp_value_in    = mem_rdata_ff;
            rsp_scrolled_in = 1'b0;
            state_in        = ST_IDLE;
         end
         ST_SCROLL: begin
            mem_we    = copy_pend_ff;
            mem_waddr = copy_wr_ff;
            mem_wdata = mem_rdata_ff;
            mem_raddr = copy_rd_ff[ADDR_W-1:0];
            if (copy_rd_ff != COPY_END) begin
               copy_wr_in   = ADDR_W'(copy_rd_ff - COPY_START);
               copy_pend_in = 1'b1;
               copy_rd_in   = copy_rd_ff + 1'b1;
            end else begin
               copy_pend_in = 1'b0;
               if (!copy_pend_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         cur_idx_ff   <= '0;
         copy_pend_ff <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= RESET_COLOR;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cur_idx_ff   <= cur_idx_in;
         copy_pend_ff <= copy_pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_rd_ff      <= copy_rd_in;
      copy_wr_ff      <= copy_wr_in;
      rd_idx_ff       <= rd_idx_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

`ifndef ASSERT_OFF
   a_cursor_index: assert property (@(posedge clock) disable iff (reset)
      int'(cur_idx_ff) == int'(row_ff) * COLUMNS + int'(col_ff))
      else $error("Cursor index does not match cursor row and column.");

   a_scroll_entry: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.op == OP_PUT && cur_idx_ff == LAST_ADDR)
      |=> (state_ff == ST_SCROLL) && rsp_scrolled_ff)
      else $error("A put at the last cell did not start a scroll.");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !mem_we)
      else $error("Screen memory written while a read result is pending.");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL || state_ff == ST_CLEAR) |-> !req_chan.ready)
      else $error("Request taken while the screen is being copied or cleared.");
`endif

endmodule
